// ----- sv/mf3_pkg.sv -----
package mf3_pkg;

  localparam int DEF_MAX_WIDTH  = 1024;
  localparam int DEF_MAX_HEIGHT = 4096;

  localparam int PIX_W       = 8;
  localparam int FW_W        = 11;
  localparam int FH_W        = 13;
  localparam int CFG_DATA_W  = 13;
  localparam int CFG_INDEX_W = 1;

  localparam int RST_FRAME_WIDTH  = 640;
  localparam int RST_FRAME_HEIGHT = 480;
  localparam int MIN_DIM          = 3;

  localparam logic [PIX_W-1:0] BORDER_VALUE = 8'd255;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  localparam logic MODE_PIXEL = 1'b0;
  localparam logic MODE_DRAIN = 1'b1;

  // Queue between the classifying front and the median back end.
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  typedef struct packed {
    logic [8:0][PIX_W-1:0] win;
    logic                  use_median;
    logic                  last;
  } mf3_entry_t;

  typedef struct packed {
    logic       valid;
    mf3_entry_t data;
  } mf3_push_t;

endpackage

// ----- sv/mf3_front.sv -----
module mf3_front import mf3_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   mode,
  input  logic [PIX_W-1:0]       pixel_in,
  input  logic [Q_CNT_W-1:0]     q_count,
  output mf3_push_t              push
);

  localparam int CW = $clog2(MAX_WIDTH);
  localparam int RW = $clog2(MAX_HEIGHT);

  localparam int W_RST = (RST_FRAME_WIDTH < MIN_DIM) ? MIN_DIM :
                         (RST_FRAME_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_FRAME_WIDTH;
  localparam int H_RST = (RST_FRAME_HEIGHT < MIN_DIM) ? MIN_DIM :
                         (RST_FRAME_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_FRAME_HEIGHT;

  logic [PIX_W-1:0] line_above     [MAX_WIDTH];
  logic [PIX_W-1:0] line_two_above [MAX_WIDTH];

  logic [CW-1:0] w_last;
  logic [RW-1:0] h_last;
  logic [CW-1:0] column_count;
  logic [RW-1:0] row_count;
  logic [CW-1:0] out_col;
  logic [RW-1:0] out_row;
  logic          input_done;

  logic                  b_valid;
  logic                  b_wr;
  logic                  b_emit;
  logic                  b_median;
  logic                  b_last;
  logic [CW-1:0]         b_col;
  logic [PIX_W-1:0]      b_pix;
  logic [PIX_W-1:0]      tap_top;
  logic [PIX_W-1:0]      tap_mid;
  logic [8:0][PIX_W-1:0] window_pixels;
  logic [8:0][PIX_W-1:0] window_next;

  logic          acc;
  logic          take_px;
  logic          emit;
  logic          pos_emits;
  logic          border;
  logic          last;
  logic [31:0]   w_clamp;
  logic [31:0]   h_clamp;
  logic [Q_CNT_W:0] occupancy;

  // Clamp the written dimension into the supported range.
  always_comb begin
    w_clamp = 32'(cfg_data[FW_W-1:0]);
    if (w_clamp < 32'(MIN_DIM)) w_clamp = 32'(MIN_DIM);
    if (w_clamp > 32'(MAX_WIDTH)) w_clamp = 32'(MAX_WIDTH);
    h_clamp = 32'(cfg_data[FH_W-1:0]);
    if (h_clamp < 32'(MIN_DIM)) h_clamp = 32'(MIN_DIM);
    if (h_clamp > 32'(MAX_HEIGHT)) h_clamp = 32'(MAX_HEIGHT);
  end

  // Reserve a queue slot for the item that is still in the memory stage.
  assign occupancy = {1'b0, q_count} + {{Q_CNT_W{1'b0}}, (b_valid & b_emit)};
  assign in_stall  = (occupancy >= (Q_CNT_W + 1)'(Q_DEPTH));
  assign acc       = in_valid & ~in_stall;

  assign pos_emits = (row_count > RW'(1)) ||
                     ((row_count == RW'(1)) && (column_count != '0));
  assign take_px   = (mode == MODE_PIXEL) & ~input_done;
  assign emit      = (mode == MODE_DRAIN) ? input_done : (take_px & pos_emits);
  assign border    = (out_row == '0) || (out_row == h_last) ||
                     (out_col == '0) || (out_col == w_last);
  assign last      = (out_row == h_last) && (out_col == w_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      w_last       <= CW'(W_RST - 1);
      h_last       <= RW'(H_RST - 1);
      column_count <= '0;
      row_count    <= '0;
      out_col      <= '0;
      out_row      <= '0;
      input_done   <= 1'b0;
      b_valid      <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_FRAME_WIDTH:  w_last <= CW'(w_clamp - 32'd1);
        REG_FRAME_HEIGHT: h_last <= RW'(h_clamp - 32'd1);
      endcase
      column_count <= '0;
      row_count    <= '0;
      out_col      <= '0;
      out_row      <= '0;
      input_done   <= 1'b0;
      b_valid      <= 1'b0;
    end else begin
      b_valid <= acc;
      if (acc && take_px) begin
        if (column_count == w_last) begin
          column_count <= '0;
          if (row_count == h_last) begin
            row_count  <= '0;
            input_done <= 1'b1;
          end else begin
            row_count <= row_count + RW'(1);
          end
        end else begin
          column_count <= column_count + CW'(1);
        end
      end
      if (acc && emit) begin
        if (last) begin
          // Frame end: restart every counter.
          column_count <= '0;
          row_count    <= '0;
          out_col      <= '0;
          out_row      <= '0;
          input_done   <= 1'b0;
        end else if (out_col == w_last) begin
          out_col <= '0;
          out_row <= out_row + RW'(1);
        end else begin
          out_col <= out_col + CW'(1);
        end
      end
    end
  end

  // Stage-B payload: read the line buffers at the accept edge.
  always_ff @(posedge clk) begin
    if (acc) begin
      tap_top  <= line_two_above[column_count];
      tap_mid  <= line_above[column_count];
      b_wr     <= take_px;
      b_emit   <= emit;
      b_median <= (mode == MODE_PIXEL) & ~border;
      b_last   <= last;
      b_col    <= column_count;
      b_pix    <= pixel_in;
    end
  end

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      window_next[r*3]     = window_pixels[r*3+1];
      window_next[r*3 + 1] = window_pixels[r*3+2];
    end
    window_next[2] = tap_top;
    window_next[5] = tap_mid;
    window_next[8] = b_pix;
  end

  // Write back the line buffers and shift the window one column.
  always_ff @(posedge clk) begin
    if (b_valid && b_wr) begin
      line_two_above[b_col] <= tap_mid;
      line_above[b_col]     <= b_pix;
      window_pixels         <= window_next;
    end
  end

  always_comb begin
    push.valid           = b_valid & b_emit;
    push.data.win        = window_next;
    push.data.use_median = b_median;
    push.data.last       = b_last;
  end

endmodule

// ----- sv/mf3_queue.sv -----
module mf3_queue import mf3_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  mf3_push_t          push,
  input  logic               pop,
  output logic               not_empty,
  output mf3_entry_t         head,
  output logic [Q_CNT_W-1:0] count
);

  mf3_entry_t         entries [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;

  assign not_empty = (count != '0);
  assign head      = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push.valid) wr_ptr <= wr_ptr + Q_PTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + Q_PTR_W'(1);
      if (push.valid && !pop) count <= count + Q_CNT_W'(1);
      else if (!push.valid && pop) count <= count - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push.valid) entries[wr_ptr] <= push.data;
  end

endmodule

// ----- sv/mf3_back.sv -----
module mf3_back import mf3_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_not_empty,
  input  mf3_entry_t       q_head,
  output logic             pop,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [PIX_W-1:0] pixel_out,
  output logic             frame_last
);

  typedef logic [PIX_W-1:0] pix_t;

  typedef struct packed {
    pix_t lo;
    pix_t mi;
    pix_t hi;
  } trio_t;

  function automatic pix_t min2(pix_t a, pix_t b);
    return (a < b) ? a : b;
  endfunction

  function automatic pix_t max2(pix_t a, pix_t b);
    return (a < b) ? b : a;
  endfunction

  function automatic pix_t med3(pix_t a, pix_t b, pix_t c);
    return max2(min2(a, b), min2(max2(a, b), c));
  endfunction

  function automatic trio_t sort3(pix_t a, pix_t b, pix_t c);
    trio_t t;
    t.lo = min2(min2(a, b), c);
    t.hi = max2(max2(a, b), c);
    t.mi = med3(a, b, c);
    return t;
  endfunction

  logic     s1_valid;
  trio_t    s1_row [3];
  logic     s1_median;
  logic     s1_last;
  logic     s2_valid;
  pix_t     s2_lo;
  pix_t     s2_mi;
  pix_t     s2_hi;
  logic     s2_median;
  logic     s2_last;
  logic     out_adv;
  logic     s2_adv;
  logic     s1_adv;

  assign out_adv = ~out_valid | ~out_stall;
  assign s2_adv  = ~s2_valid | out_adv;
  assign s1_adv  = ~s1_valid | s2_adv;
  assign pop     = q_not_empty & s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      s2_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (s1_adv) s1_valid <= q_not_empty;
      if (s2_adv) s2_valid <= s1_valid;
      if (out_adv) out_valid <= s2_valid;
    end
  end

  // Sort each window row.
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      for (int r = 0; r < 3; r++) begin
        s1_row[r] <= sort3(q_head.win[r*3], q_head.win[r*3+1], q_head.win[r*3+2]);
      end
      s1_median <= q_head.use_median;
      s1_last   <= q_head.last;
    end
  end

  // Reduce to three candidates: max of lows, median of mids, min of highs.
  always_ff @(posedge clk) begin
    if (s2_adv) begin
      s2_lo     <= max2(max2(s1_row[0].lo, s1_row[1].lo), s1_row[2].lo);
      s2_mi     <= med3(s1_row[0].mi, s1_row[1].mi, s1_row[2].mi);
      s2_hi     <= min2(min2(s1_row[0].hi, s1_row[1].hi), s1_row[2].hi);
      s2_median <= s1_median;
      s2_last   <= s1_last;
    end
  end

  always_ff @(posedge clk) begin
    if (out_adv) begin
      pixel_out  <= s2_median ? med3(s2_lo, s2_mi, s2_hi) : BORDER_VALUE;
      frame_last <= s2_last;
    end
  end

endmodule

// ----- sv/median_filter_3x3_white_border_unit.sv -----
// 3x3 median filter with a white border. Pixels enter in raster order, one per clock
// when neither side stalls; each accepted beat (pixel or drain tick) passes through the
// front end, and results leave at the same rate. Output pixels follow the input by
// frame_width+1 pixels in stream order; after the last input pixel of a frame, send
// frame_width+1 drain beats (mode=1) to flush the trailing border row. Interior pixels are
// the median of the 3x3 neighborhood; the first and last rows and columns read 255, and
// frame_last marks the final pixel of the frame. Pixels sent while a frame drains and drain
// beats sent mid-frame are dropped without a result. A register write restarts the frame;
// write only while the block is idle. Width and height are clamped to [3, MAX_WIDTH] and
// [3, MAX_HEIGHT]. From input accept to output valid, a beat passes the line-buffer read
// register, the queue, and three median stages.
module median_filter_3x3_white_border_unit import mf3_pkg::*; #(
  parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
  parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   mode,
  input  logic [PIX_W-1:0]       pixel_in,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [PIX_W-1:0]       pixel_out,
  output logic                   frame_last
);

  mf3_push_t          push;
  logic               pop;
  logic               q_not_empty;
  mf3_entry_t         q_head;
  logic [Q_CNT_W-1:0] q_count;

  // Registers are always writable; the front end applies them at once.
  assign cfg_ready = 1'b1;

  // Front: position counters, beat classification, line buffers and window.
  mf3_front #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .mode      (mode),
    .pixel_in  (pixel_in),
    .q_count   (q_count),
    .push      (push)
  );

  // Hold classified windows so the output side can stall on its own.
  mf3_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (pop),
    .not_empty (q_not_empty),
    .head      (q_head),
    .count     (q_count)
  );

  // Back: pipelined median network and output register.
  mf3_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .pixel_out   (pixel_out),
    .frame_last  (frame_last)
  );

endmodule
